FILE: rtl/eihp_pkg.sv
`timescale 1ns / 1ps

package eihp_pkg;

  // Frame length counter
  localparam int LEN_W   = 11;
  localparam int LEN_MAX = 2047;

  // Header geometry, in bytes
  localparam int ETH_HDR      = 14;
  localparam int VLAN_TAG     = 4;
  localparam int IP_FIX       = 20;
  localparam int TCP_FIX      = 20;
  localparam int UDP_FIX      = 8;
  localparam int VLAN_MIN_LEN = ETH_HDR + VLAN_TAG + IP_FIX;

  // High and low ethertype bytes that are recognised
  localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETYPE_VLAN_HI = 8'h81;
  localparam logic [7:0] ETYPE_LO      = 8'h00;

  // IP protocol numbers
  localparam logic [7:0] PROTO_TCP = 8'h06;
  localparam logic [7:0] PROTO_UDP = 8'h11;

  // Configuration register indices and reset values
  localparam logic [0:0] REG_MIN_LEN = 1'b0;
  localparam logic [0:0] REG_MAX_LEN = 1'b1;
  localparam logic [LEN_W-1:0] MIN_LEN_RST = 11'd34;
  localparam logic [LEN_W-1:0] MAX_LEN_RST = 11'd1518;

  typedef enum logic [1:0] {
    CLASS_UNKNOWN = 2'd0,
    CLASS_TCP     = 2'd1,
    CLASS_UDP     = 2'd2
  } proto_class_e;

  // Header fields of one completed frame, as caught from the byte stream
  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] len;
    logic [7:0]       etype_hi;
    logic [7:0]       etype_lo;
    logic [3:0]       ihl;
    logic [15:0]      total;
    logic [7:0]       proto;
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
    logic [15:0]      src_port;
    logic [15:0]      dst_port;
    logic [31:0]      seq_num;
    logic [31:0]      ack_num;
    logic [3:0]       thl;
  } frame_t;

endpackage

FILE: rtl/eihp_in_if.sv
`timescale 1ns / 1ps

interface eihp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/eihp_out_if.sv
`timescale 1ns / 1ps

interface eihp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  protocol_class;
  logic        vlan_tagged;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [31:0] sequence_number;
  logic [31:0] acknowledge_number;
  logic [7:0]  payload_offset;
  logic [10:0] payload_size;

  modport source (
    output valid, output protocol_class, output vlan_tagged,
    output source_address, output dest_address, output source_port,
    output dest_port, output sequence_number, output acknowledge_number,
    output payload_offset, output payload_size,
    input  ready
  );
  modport sink (
    input  valid, input protocol_class, input vlan_tagged,
    input  source_address, input dest_address, input source_port,
    input  dest_port, input sequence_number, input acknowledge_number,
    input  payload_offset, input payload_size,
    output ready
  );
endinterface

FILE: rtl/eihp_capture.sv
`timescale 1ns / 1ps

module eihp_capture (
  input  logic            clk_i,
  input  logic            rst_ni,
  eihp_in_if.sink         in_req,
  input  logic            take_i,
  output eihp_pkg::frame_t frame_o
);

  localparam int ETYPE_POS    = 12;
  localparam int IP_TOT_REL   = 2;
  localparam int IP_PROTO_REL = 9;
  localparam int IP_SRC_REL   = 12;
  localparam int IP_DST_REL   = 16;
  localparam int L4_DPORT_REL = 2;
  localparam int L4_SEQ_REL   = 4;
  localparam int L4_ACK_REL   = 8;
  localparam int L4_THL_REL   = 12;

  logic [eihp_pkg::LEN_W-1:0] cnt_q, cnt_d;
  logic [eihp_pkg::LEN_W-1:0] len_q, len_d;
  logic                       pend_q, pend_d;
  logic                       acc;

  logic [7:0]  etype_hi_q, etype_hi_d;
  logic [7:0]  etype_lo_q, etype_lo_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [15:0] total_q, total_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_addr_q, src_addr_d;
  logic [31:0] dst_addr_q, dst_addr_d;
  logic [15:0] src_port_q, src_port_d;
  logic [15:0] dst_port_q, dst_port_d;
  logic [31:0] seq_num_q, seq_num_d;
  logic [31:0] ack_num_q, ack_num_d;
  logic [3:0]  thl_q, thl_d;

  logic [eihp_pkg::LEN_W-1:0] ip_off, l4_off, ip_rel, l4_rel;
  logic [3:0]                 ihl_cur;
  logic                       ip_in, l4_in;

  assign in_req.ready = !pend_q || take_i;
  assign acc          = in_req.valid && in_req.ready;

  // The transport header offset may begin at the IHL byte itself, so the IHL
  // nibble is taken from the live byte while that byte is passing.
  always_comb begin
    ip_off  = (etype_hi_q == eihp_pkg::ETYPE_VLAN_HI) ?
              eihp_pkg::LEN_W'(eihp_pkg::ETH_HDR + eihp_pkg::VLAN_TAG) :
              eihp_pkg::LEN_W'(eihp_pkg::ETH_HDR);
    ihl_cur = (cnt_q == ip_off) ? in_req.data_byte[3:0] : ihl_q;
    l4_off  = ip_off + {5'd0, ihl_cur, 2'b00};
    ip_in   = cnt_q >= ip_off;
    l4_in   = cnt_q >= l4_off;
    ip_rel  = cnt_q - ip_off;
    l4_rel  = cnt_q - l4_off;
  end

  always_comb begin
    cnt_d  = cnt_q;
    len_d  = len_q;
    pend_d = pend_q;
    if (take_i) begin
      pend_d = 1'b0;
    end
    if (acc) begin
      if (in_req.last_byte) begin
        cnt_d  = '0;
        len_d  = (cnt_q == eihp_pkg::LEN_W'(eihp_pkg::LEN_MAX)) ? cnt_q :
                 cnt_q + 1'b1;
        pend_d = 1'b1;
      end else if (cnt_q != eihp_pkg::LEN_W'(eihp_pkg::LEN_MAX)) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    etype_hi_d = etype_hi_q;
    etype_lo_d = etype_lo_q;
    ihl_d      = ihl_q;
    total_d    = total_q;
    proto_d    = proto_q;
    src_addr_d = src_addr_q;
    dst_addr_d = dst_addr_q;
    src_port_d = src_port_q;
    dst_port_d = dst_port_q;
    seq_num_d  = seq_num_q;
    ack_num_d  = ack_num_q;
    thl_d      = thl_q;
    if (acc) begin
      // Bytes not seen in this frame must read as zero.
      if (cnt_q == '0) begin
        etype_hi_d = '0;
        etype_lo_d = '0;
        ihl_d      = '0;
        total_d    = '0;
        proto_d    = '0;
        src_addr_d = '0;
        dst_addr_d = '0;
        src_port_d = '0;
        dst_port_d = '0;
        seq_num_d  = '0;
        ack_num_d  = '0;
        thl_d      = '0;
      end
      if (cnt_q == eihp_pkg::LEN_W'(ETYPE_POS)) begin
        etype_hi_d = in_req.data_byte;
      end
      if (cnt_q == eihp_pkg::LEN_W'(ETYPE_POS + 1)) begin
        etype_lo_d = in_req.data_byte;
      end
      if (ip_in) begin
        if (ip_rel == '0) begin
          ihl_d = in_req.data_byte[3:0];
        end
        if (ip_rel == eihp_pkg::LEN_W'(IP_TOT_REL)) begin
          total_d[15:8] = in_req.data_byte;
        end
        if (ip_rel == eihp_pkg::LEN_W'(IP_TOT_REL + 1)) begin
          total_d[7:0] = in_req.data_byte;
        end
        if (ip_rel == eihp_pkg::LEN_W'(IP_PROTO_REL)) begin
          proto_d = in_req.data_byte;
        end
        for (int k = 0; k < 4; k++) begin
          if (ip_rel == eihp_pkg::LEN_W'(IP_SRC_REL + k)) begin
            src_addr_d[8*(3-k) +: 8] = in_req.data_byte;
          end
          if (ip_rel == eihp_pkg::LEN_W'(IP_DST_REL + k)) begin
            dst_addr_d[8*(3-k) +: 8] = in_req.data_byte;
          end
        end
      end
      if (l4_in) begin
        for (int k = 0; k < 2; k++) begin
          if (l4_rel == eihp_pkg::LEN_W'(k)) begin
            src_port_d[8*(1-k) +: 8] = in_req.data_byte;
          end
          if (l4_rel == eihp_pkg::LEN_W'(L4_DPORT_REL + k)) begin
            dst_port_d[8*(1-k) +: 8] = in_req.data_byte;
          end
        end
        for (int k = 0; k < 4; k++) begin
          if (l4_rel == eihp_pkg::LEN_W'(L4_SEQ_REL + k)) begin
            seq_num_d[8*(3-k) +: 8] = in_req.data_byte;
          end
          if (l4_rel == eihp_pkg::LEN_W'(L4_ACK_REL + k)) begin
            ack_num_d[8*(3-k) +: 8] = in_req.data_byte;
          end
        end
        if (l4_rel == eihp_pkg::LEN_W'(L4_THL_REL)) begin
          thl_d = in_req.data_byte[7:4];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    etype_hi_q <= etype_hi_d;
    etype_lo_q <= etype_lo_d;
    ihl_q      <= ihl_d;
    total_q    <= total_d;
    proto_q    <= proto_d;
    src_addr_q <= src_addr_d;
    dst_addr_q <= dst_addr_d;
    src_port_q <= src_port_d;
    dst_port_q <= dst_port_d;
    seq_num_q  <= seq_num_d;
    ack_num_q  <= ack_num_d;
    thl_q      <= thl_d;
  end

  always_comb begin
    frame_o.done     = pend_q;
    frame_o.len      = len_q;
    frame_o.etype_hi = etype_hi_q;
    frame_o.etype_lo = etype_lo_q;
    frame_o.ihl      = ihl_q;
    frame_o.total    = total_q;
    frame_o.proto    = proto_q;
    frame_o.src_addr = src_addr_q;
    frame_o.dst_addr = dst_addr_q;
    frame_o.src_port = src_port_q;
    frame_o.dst_port = dst_port_q;
    frame_o.seq_num  = seq_num_q;
    frame_o.ack_num  = ack_num_q;
    frame_o.thl      = thl_q;
  end

endmodule

FILE: rtl/eihp_parse.sv
`timescale 1ns / 1ps

module eihp_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  eihp_pkg::frame_t           frame_i,
  input  logic [eihp_pkg::LEN_W-1:0] min_len_i,
  input  logic [eihp_pkg::LEN_W-1:0] max_len_i,
  output logic                       take_o,
  eihp_out_if.source                 out_res
);

  logic                       valid_q;
  eihp_pkg::proto_class_e     class_q, class_d;
  logic                       vlan_q, vlan_d;
  logic [31:0]                src_addr_q, src_addr_d, dst_addr_q, dst_addr_d;
  logic [15:0]                src_port_q, src_port_d, dst_port_q, dst_port_d;
  logic [31:0]                seq_q, seq_d, ack_q, ack_d;
  logic [7:0]                 poff_q, poff_d;
  logic [eihp_pkg::LEN_W-1:0] psize_q, psize_d;

  logic                       is_ipv4, is_vlan, ip_ok, tcp_ok, udp_ok;
  logic [6:0]                 ip_off, l4_off;
  logic [5:0]                 ihl4, thl4;
  logic [eihp_pkg::LEN_W-1:0] avail, body, l4_off_w;
  logic [15:0]                body_raw;

  assign take_o = frame_i.done && (!valid_q || out_res.ready);

  always_comb begin
    is_ipv4 = frame_i.etype_hi == eihp_pkg::ETYPE_IPV4_HI;
    is_vlan = frame_i.etype_hi == eihp_pkg::ETYPE_VLAN_HI;
    ip_ok   = (frame_i.len >= min_len_i) && (frame_i.len <= max_len_i) &&
              (frame_i.etype_lo == eihp_pkg::ETYPE_LO) && (is_ipv4 || is_vlan) &&
              (!is_vlan || frame_i.len >= eihp_pkg::LEN_W'(eihp_pkg::VLAN_MIN_LEN));

    ip_off   = is_vlan ? 7'(eihp_pkg::ETH_HDR + eihp_pkg::VLAN_TAG) :
               7'(eihp_pkg::ETH_HDR);
    ihl4     = {frame_i.ihl, 2'b00};
    thl4     = {frame_i.thl, 2'b00};
    l4_off   = ip_off + {1'b0, ihl4};
    l4_off_w = {4'd0, l4_off};

    // Body length is clamped to what was captured past the IP header.
    avail    = (frame_i.len >= l4_off_w) ? frame_i.len - l4_off_w : '0;
    body_raw = frame_i.total - {10'd0, ihl4};
    if ((frame_i.total < {10'd0, ihl4}) || (body_raw > {5'd0, avail})) begin
      body = avail;
    end else begin
      body = body_raw[eihp_pkg::LEN_W-1:0];
    end

    tcp_ok = ip_ok && (frame_i.proto == eihp_pkg::PROTO_TCP) &&
             (l4_off_w + eihp_pkg::LEN_W'(eihp_pkg::TCP_FIX) <= frame_i.len) &&
             (body >= {5'd0, thl4});
    udp_ok = ip_ok && (frame_i.proto == eihp_pkg::PROTO_UDP) &&
             (l4_off_w + eihp_pkg::LEN_W'(eihp_pkg::UDP_FIX) <= frame_i.len);

    class_d    = tcp_ok ? eihp_pkg::CLASS_TCP :
                 udp_ok ? eihp_pkg::CLASS_UDP : eihp_pkg::CLASS_UNKNOWN;
    vlan_d     = ip_ok && is_vlan;
    src_addr_d = ip_ok ? frame_i.src_addr : '0;
    dst_addr_d = ip_ok ? frame_i.dst_addr : '0;
    src_port_d = (tcp_ok || udp_ok) ? frame_i.src_port : '0;
    dst_port_d = (tcp_ok || udp_ok) ? frame_i.dst_port : '0;
    seq_d      = tcp_ok ? frame_i.seq_num : '0;
    ack_d      = tcp_ok ? frame_i.ack_num : '0;
    poff_d     = tcp_ok ? ({1'b0, l4_off} + {2'b00, thl4}) : '0;
    psize_d    = tcp_ok ? body - {5'd0, thl4} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= 1'b1;
    end else if (out_res.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      class_q    <= class_d;
      vlan_q     <= vlan_d;
      src_addr_q <= src_addr_d;
      dst_addr_q <= dst_addr_d;
      src_port_q <= src_port_d;
      dst_port_q <= dst_port_d;
      seq_q      <= seq_d;
      ack_q      <= ack_d;
      poff_q     <= poff_d;
      psize_q    <= psize_d;
    end
  end

  assign out_res.valid              = valid_q;
  assign out_res.protocol_class     = class_q;
  assign out_res.vlan_tagged        = vlan_q;
  assign out_res.source_address     = src_addr_q;
  assign out_res.dest_address       = dst_addr_q;
  assign out_res.source_port        = src_port_q;
  assign out_res.dest_port          = dst_port_q;
  assign out_res.sequence_number    = seq_q;
  assign out_res.acknowledge_number = ack_q;
  assign out_res.payload_offset     = poff_q;
  assign out_res.payload_size       = psize_q;

endmodule

FILE: rtl/eth_ipv4_l4_header_parser_unit.sv
`timescale 1ns / 1ps

// Ethernet / IPv4 / TCP-UDP header parser. Each request on in_req carries one
// byte of a captured frame in wire order, with last_byte set on its final
// byte; one request per cycle is taken. Rather than buffering the header, the
// block picks the fields it needs out of the byte stream as they pass, using
// the byte counter and the ethertype and IHL seen so far to place them, so
// any byte that the frame never delivered reads as zero. After the last byte is
// taken, a single-pass classifier turns the caught fields into one result
// request on out_res: the length window, the ethertype (IPv4 or an
// 802.1Q tag, whose length check counts the tag), then TCP, UDP or unknown,
// with the IP body length clamped to the captured bytes. Input is accepted
// every cycle; it is held off only while a finished frame waits for the
// result register, which is full and not being drained. The length window is
// set through the write port: register 0 is the minimum length (reset 34),
// register 1 the maximum (reset 1518); the user must write them only while no
// frame is in progress, which the block itself does not enforce.

module eth_ipv4_l4_header_parser_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  eihp_in_if.sink                    in_req,
  eihp_out_if.source                 out_res,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [eihp_pkg::LEN_W-1:0] cfg_data_i
);

  logic [eihp_pkg::LEN_W-1:0] min_len_q, max_len_q;
  eihp_pkg::frame_t           frame;
  logic                       take;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= eihp_pkg::MIN_LEN_RST;
      max_len_q <= eihp_pkg::MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        eihp_pkg::REG_MIN_LEN: min_len_q <= cfg_data_i;
        eihp_pkg::REG_MAX_LEN: max_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Byte counter and on-the-fly field capture
  eihp_capture u_capture (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_req  (in_req),
    .take_i  (take),
    .frame_o (frame)
  );

  // Classification and result register
  eihp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .frame_i   (frame),
    .min_len_i (min_len_q),
    .max_len_i (max_len_q),
    .take_o    (take),
    .out_res   (out_res)
  );

  // A finished frame that cannot move on must hold the input off.
  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame.done && out_res.valid && !out_res.ready |-> !in_req.ready)
    else $error("input taken while a finished frame is blocked");

  // Every last byte taken leaves a finished frame for the classifier.
  a_last_marks_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req.valid && in_req.ready && in_req.last_byte |=> frame.done)
    else $error("last byte did not complete a frame");

  // Only TCP results carry sequence, acknowledge and payload fields.
  a_non_tcp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_res.valid && out_res.protocol_class != eihp_pkg::CLASS_TCP |->
      out_res.sequence_number == '0 && out_res.acknowledge_number == '0 &&
      out_res.payload_offset == '0 && out_res.payload_size == '0)
    else $error("non-TCP result carries TCP fields");

  // Unknown results carry no ports.
  a_unknown_no_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_res.valid && out_res.protocol_class == eihp_pkg::CLASS_UNKNOWN |->
      out_res.source_port == '0 && out_res.dest_port == '0)
    else $error("unknown result carries ports");

endmodule
